/* hdl/matrix_row_column_reduce_unit_assert.svh */
// Assertion macros for the row/column reduction block.
// Each macro is a full concurrent assertion statement; simulation builds get
// the check, synthesis builds get nothing.
`ifndef MATRIX_ROW_COLUMN_REDUCE_UNIT_ASSERT_SVH
`define MATRIX_ROW_COLUMN_REDUCE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge out of reset.
`define MRCR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true at a clock edge out of reset.
`define MRCR_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define MRCR_ASSERT(label, clk, rst_n, prop, msg)

`define MRCR_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

/* hdl/mrcr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mrcr_pkg;

    localparam int PIXEL_W    = 8;
    localparam int RESULT_W   = 18;
    localparam int SIZE_W     = 11;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 24;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    localparam int MAX_COLS_DEF = 1024;
    localparam int MAX_ROWS_DEF = 1024;

    localparam logic [RESULT_W-1:0] SUM_LIMIT = '1;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_REDUCE_OP  = 2'd0;
    localparam logic [1:0] REG_ALONG_ROWS = 2'd1;
    localparam logic [1:0] REG_NUM_ROWS   = 2'd2;
    localparam logic [1:0] REG_NUM_COLS   = 2'd3;

    // reduction operations
    localparam logic [1:0] OP_SUM = 2'd0;
    localparam logic [1:0] OP_AVG = 2'd1;
    localparam logic [1:0] OP_MAX = 2'd2;
    localparam logic [1:0] OP_MIN = 2'd3;

    localparam logic [SIZE_W-1:0] NUM_ROWS_RST = 11'd128;
    localparam logic [SIZE_W-1:0] NUM_COLS_RST = 11'd128;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

/* hdl/mrcr_div.sv */
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider: one quotient bit per cycle, MSB first.
module mrcr_div #(
    parameter int DIV_W = 11
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           start,
    input  wire logic [mrcr_pkg::RESULT_W-1:0]  dividend,
    input  wire logic [DIV_W-1:0]               divisor,
    output mrcr_pkg::div_stat_t                 stat,
    output logic      [mrcr_pkg::RESULT_W-1:0]  quotient
);

    localparam int QW  = mrcr_pkg::RESULT_W;
    localparam int CNT_W = $clog2(QW);

    logic [DIV_W-1:0] rem_reg;
    logic [QW-1:0]    quo_reg;
    logic [DIV_W-1:0] div_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DIV_W:0]   trial;
    logic             fits;
    logic [DIV_W-1:0] rem_next;

    always_comb begin
        trial    = {rem_reg, quo_reg[QW-1]};
        fits     = trial >= {1'b0, div_reg};
        rem_next = fits ? DIV_W'(trial - {1'b0, div_reg}) : trial[DIV_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(QW - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[QW-2:0], fits};
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire

/* hdl/matrix_row_column_reduce_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Row/column reduction of a gray image streamed in raster order, one 8-bit
// pixel per transaction. With along_rows set, each row collapses into one
// value that leaves with the row's last pixel; with it clear, a per-column
// accumulator memory (MAX_COLS entries, registered read) holds running
// values and each column's result leaves with its pixel in the last row,
// in column order. reduce_op picks sum (saturating at 2^18-1), truncated
// average, maximum or minimum; the first pixel of a row or column seeds
// its accumulator. Sizes of 0 act as 1, sizes above MAX_ROWS/MAX_COLS act
// as the maximum. The block works on one pixel at a time: a pixel that
// closes no row or column is accepted with a memory read, then combined
// and written back; one with a result also passes the one-bit-per-cycle
// divider if averaging, then the output stage. The result sits
// in an output register, so the next pixel is accepted while it waits;
// only a second result blocks until the first is taken. m_tlast marks the
// final result of the image. Write the registers only while idle.
module matrix_row_column_reduce_unit #(
    parameter int MAX_COLS = mrcr_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = mrcr_pkg::MAX_ROWS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    // pixel input
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [mrcr_pkg::S_TDATA_W-1:0]    s_tdata,   // [7:0] pixel

    // result output
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [mrcr_pkg::M_TDATA_W-1:0]    m_tdata,   // [17:0] result_value, rest zero
    output logic                                   m_tlast,   // last_result

    // configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [mrcr_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [mrcr_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [mrcr_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready
);

    `include "matrix_row_column_reduce_unit_assert.svh"

    localparam int RES_W  = mrcr_pkg::RESULT_W;
    localparam int PIX_W  = mrcr_pkg::PIXEL_W;
    localparam int SZ_W   = mrcr_pkg::SIZE_W;
    localparam int CW     = $clog2(MAX_COLS);
    localparam int RW     = $clog2(MAX_ROWS);
    localparam int CNW    = $clog2(MAX_COLS + 1);
    localparam int RNW    = $clog2(MAX_ROWS + 1);
    localparam int DIV_W  = (CNW > RNW) ? CNW : RNW;
    localparam int CMP_A  = (CNW > RNW) ? CNW : RNW;
    localparam int CMP_W  = (CMP_A > SZ_W) ? CMP_A : SZ_W;

    localparam logic [CMP_W-1:0] MAX_COLS_C = CMP_W'(MAX_COLS);
    localparam logic [CMP_W-1:0] MAX_ROWS_C = CMP_W'(MAX_ROWS);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_COMB = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [1:0]      reduce_op_reg;
    logic            along_rows_reg;
    logic [SZ_W-1:0] num_rows_reg;
    logic [SZ_W-1:0] num_cols_reg;
    logic            cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reduce_op_reg  <= mrcr_pkg::OP_SUM;
            along_rows_reg <= 1'b1;
            num_rows_reg   <= mrcr_pkg::NUM_ROWS_RST;
            num_cols_reg   <= mrcr_pkg::NUM_COLS_RST;
        end else if (cfg_write) begin
            case (paddr[3:2])
                mrcr_pkg::REG_REDUCE_OP:  reduce_op_reg  <= pwdata[1:0];
                mrcr_pkg::REG_ALONG_ROWS: along_rows_reg <= pwdata[0];
                mrcr_pkg::REG_NUM_ROWS:   num_rows_reg   <= pwdata[SZ_W-1:0];
                mrcr_pkg::REG_NUM_COLS:   num_cols_reg   <= pwdata[SZ_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            mrcr_pkg::REG_REDUCE_OP:  prdata = mrcr_pkg::APB_DATA_W'(reduce_op_reg);
            mrcr_pkg::REG_ALONG_ROWS: prdata = mrcr_pkg::APB_DATA_W'(along_rows_reg);
            mrcr_pkg::REG_NUM_ROWS:   prdata = mrcr_pkg::APB_DATA_W'(num_rows_reg);
            mrcr_pkg::REG_NUM_COLS:   prdata = mrcr_pkg::APB_DATA_W'(num_cols_reg);
            default:                  prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Effective sizes: clamp 0 up to 1 and large values down to the max
    // ---------------------------------------------------------------
    logic [CMP_W-1:0] ncols_ext, nrows_ext, ncols_w, nrows_w;
    logic [CNW-1:0]   eff_nc;
    logic [RNW-1:0]   eff_nr;

    always_comb begin
        ncols_ext = CMP_W'(num_cols_reg);
        nrows_ext = CMP_W'(num_rows_reg);
        if (ncols_ext == '0) begin
            ncols_w = CMP_W'(1);
        end else if (ncols_ext > MAX_COLS_C) begin
            ncols_w = MAX_COLS_C;
        end else begin
            ncols_w = ncols_ext;
        end
        if (nrows_ext == '0) begin
            nrows_w = CMP_W'(1);
        end else if (nrows_ext > MAX_ROWS_C) begin
            nrows_w = MAX_ROWS_C;
        end else begin
            nrows_w = nrows_ext;
        end
        eff_nc = ncols_w[CNW-1:0];
        eff_nr = nrows_w[RNW-1:0];
    end

    // ---------------------------------------------------------------
    // Position tracking, evaluated at pixel accept
    // ---------------------------------------------------------------
    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] col_index_reg, col_index_next;
    logic [RW-1:0] row_index_reg, row_index_next;
    logic [CW-1:0] col_use;
    logic [RW-1:0] row_use;
    logic          last_col, last_row;
    logic          s_accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        // restart a position that lies past a shrunken size
        col_use  = (CNW'(col_index_reg) >= eff_nc) ? '0 : col_index_reg;
        row_use  = (RNW'(row_index_reg) >= eff_nr) ? '0 : row_index_reg;
        last_col = (CNW'(col_use) == eff_nc - CNW'(1));
        last_row = (RNW'(row_use) == eff_nr - RNW'(1));
        if (last_col) begin
            col_index_next = '0;
            row_index_next = last_row ? '0 : row_use + RW'(1);
        end else begin
            col_index_next = col_use + CW'(1);
            row_index_next = row_use;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_index_reg <= '0;
            row_index_reg <= '0;
        end else if (s_accept) begin
            col_index_reg <= col_index_next;
            row_index_reg <= row_index_next;
        end
    end

    // per-item context, captured at accept
    logic [PIX_W-1:0] px_reg;
    logic [CW-1:0]    col_q_reg;
    logic             first_reg;
    logic             emit_reg;
    logic             res_last_reg;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            px_reg       <= s_tdata[PIX_W-1:0];
            col_q_reg    <= col_use;
            first_reg    <= along_rows_reg ? (col_use == '0) : (row_use == '0);
            emit_reg     <= along_rows_reg ? last_col : last_row;
            res_last_reg <= along_rows_reg ? last_row : last_col;
        end
    end

    // ---------------------------------------------------------------
    // Column accumulator memory: read at accept, write back in ST_COMB.
    // A read always comes after the previous write-back has landed, so
    // no forwarding path is needed.
    // ---------------------------------------------------------------
    logic [RES_W-1:0] col_mem [MAX_COLS];
    logic [RES_W-1:0] mem_rdata_reg;
    logic             mem_we;
    logic [RES_W-1:0] acc_new;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            mem_rdata_reg <= col_mem[col_use];
        end
        if (mem_we) begin
            col_mem[col_q_reg] <= acc_new;
        end
    end

    // ---------------------------------------------------------------
    // Combine
    // ---------------------------------------------------------------
    logic [RES_W-1:0] row_acc_reg;
    logic [RES_W-1:0] acc_old;
    logic [RES_W-1:0] px_ext;
    logic [RES_W:0]   sum_full;
    logic [RES_W-1:0] sum_sat;

    always_comb begin
        acc_old  = along_rows_reg ? row_acc_reg : mem_rdata_reg;
        px_ext   = RES_W'(px_reg);
        sum_full = {1'b0, acc_old} + {1'b0, px_ext};
        sum_sat  = sum_full[RES_W] ? mrcr_pkg::SUM_LIMIT : sum_full[RES_W-1:0];
        if (first_reg) begin
            acc_new = px_ext;
        end else begin
            case (reduce_op_reg)
                mrcr_pkg::OP_MAX: acc_new = (acc_old > px_ext) ? acc_old : px_ext;
                mrcr_pkg::OP_MIN: acc_new = (acc_old < px_ext) ? acc_old : px_ext;
                default:          acc_new = sum_sat;
            endcase
        end
    end

    assign mem_we = (state_reg == ST_COMB) && !along_rows_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_acc_reg <= '0;
        end else if (state_reg == ST_COMB && along_rows_reg) begin
            row_acc_reg <= acc_new;
        end
    end

    // ---------------------------------------------------------------
    // Divider for averages
    // ---------------------------------------------------------------
    mrcr_pkg::div_stat_t div_stat;
    logic [RES_W-1:0]    div_quot;
    logic                div_start;
    logic [DIV_W-1:0]    div_divisor;

    assign div_start   = (state_reg == ST_COMB) && emit_reg
                         && (reduce_op_reg == mrcr_pkg::OP_AVG);
    assign div_divisor = along_rows_reg ? DIV_W'(eff_nc) : DIV_W'(eff_nr);

    mrcr_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc_new),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    logic [RES_W-1:0] res_reg;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             out_load;

    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_accept) begin
                state_next = ST_COMB;
            end
            ST_COMB: begin
                if (!emit_reg) begin
                    state_next = ST_IDLE;
                end else if (reduce_op_reg == mrcr_pkg::OP_AVG) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV: if (div_stat.done) begin
                state_next = ST_OUT;
            end
            ST_OUT: if (out_load) begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // hold the finished value until the output register is free
    always_ff @(posedge aclk) begin
        if (state_reg == ST_COMB) begin
            res_reg <= acc_new;
        end else if (state_reg == ST_DIV && div_stat.done) begin
            res_reg <= div_quot;
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    logic [RES_W-1:0] m_value_reg;
    logic             m_last_reg;

    always_comb begin
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_value_reg <= res_reg;
            m_last_reg  <= res_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = mrcr_pkg::M_TDATA_W'(m_value_reg);
    assign m_tlast  = m_last_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `MRCR_ASSERT(a_accept_to_comb, aclk, aresetn, s_accept |=> (state_reg == ST_COMB), "accepted pixel did not reach combine")
    `MRCR_ASSERT(a_div_done_in_div, aclk, aresetn, div_stat.done |-> (state_reg == ST_DIV), "divider finished outside divide state")
    `MRCR_ASSERT(a_div_alive, aclk, aresetn, (state_reg == ST_DIV) |-> (div_stat.busy || div_stat.done), "divide state waits on idle divider")
    `MRCR_NEVER(a_no_overwrite, aclk, aresetn, out_load && m_tvalid_reg && !m_tready, "pending result overwritten")

endmodule

`default_nettype wire
